// ----- rtl/omre_pkg.sv -----
package omre_pkg;

   // store size and derived widths
   localparam int CAPACITY = 1024;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths
   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;
   localparam int RSP_W    = ((DATA_W + STATUS_W + 7) / 8) * 8;

   // reduction tree shape: two registered levels of FOLD_N-wide folds
   localparam int FOLD_N    = 32;
   localparam int GROUPS    = (CAPACITY + FOLD_N - 1) / FOLD_N;
   localparam int L2_GROUPS = (GROUPS + FOLD_N - 1) / FOLD_N;

   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT = 3'd0,
      FN_DELETE = 3'd1,
      FN_RANK   = 3'd2,
      FN_KTH    = 3'd3,
      FN_PRED   = 3'd4,
      FN_SUCC   = 3'd5
   } func_type;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   // operation broadcast to every cell
   typedef struct packed {
      func_type                  func;
      logic signed [DATA_W-1:0]  operand;
   } op_type;

   // shift command applied to the whole chain
   typedef struct packed {
      logic ins;
      logic del;
   } commit_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic                      lt;
      logic                      le;
      logic signed [DATA_W-1:0]  value;
   } view_type;

   // one candidate answer, at most one is set per query
   typedef struct packed {
      logic                hit;
      logic [DATA_W-1:0]   data;
   } tag_type;

endpackage

// ----- rtl/omre_cell.sv -----
module omre_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [omre_pkg::IDX_W-1:0]      cell_index,
   input  logic [omre_pkg::CNT_W-1:0]      live,
   input  omre_pkg::op_type                op,
   input  omre_pkg::commit_type            commit,
   input  omre_pkg::view_type              left,
   input  omre_pkg::view_type              right,
   output omre_pkg::view_type              view,
   output omre_pkg::tag_type               tag
);

   logic signed [omre_pkg::DATA_W-1:0] value_ff;
   logic signed [omre_pkg::DATA_W-1:0] value_in;
   logic                               lt_ff;
   logic                               le_ff;
   logic                               lt_in;
   logic                               le_in;
   omre_pkg::tag_type                  tag_ff;
   omre_pkg::tag_type                  tag_in;
   logic                               valid;
   logic [omre_pkg::DATA_W-1:0]        pos1;

   // entry is live when it sits below the fill count
   assign valid = omre_pkg::CNT_W'(cell_index) < live;
   assign pos1  = omre_pkg::DATA_W'(cell_index) + omre_pkg::DATA_W'(1);

   // local compare against the broadcast operand
   assign lt_in = valid && (value_ff <  op.operand);
   assign le_in = valid && (value_ff <= op.operand);

   // candidate answer from own flags and neighbor flags
   always_comb begin
      tag_in.hit  = 1'b0;
      tag_in.data = value_ff;
      unique case (op.func)
         omre_pkg::FN_RANK: begin
            tag_in.hit  = lt_ff && !right.lt;
            tag_in.data = pos1;
         end
         omre_pkg::FN_KTH: begin
            tag_in.hit = valid && ($unsigned(op.operand) == pos1);
         end
         omre_pkg::FN_PRED: begin
            tag_in.hit = lt_ff && !right.lt;
         end
         omre_pkg::FN_SUCC: begin
            tag_in.hit = valid && !le_ff && left.le;
         end
         omre_pkg::FN_DELETE: begin
            tag_in.hit = le_ff && !lt_ff && left.lt;
         end
         default: begin
            tag_in.hit = 1'b0;
         end
      endcase
   end

   // shift right on insert, shift left on delete
   always_comb begin
      value_in = value_ff;
      if (commit.ins && !le_ff) begin
         value_in = left.le ? op.operand : left.value;
      end else if (commit.del && !lt_ff) begin
         value_in = right.value;
      end
   end

   // stored value
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // flags and candidate
   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff      <= 1'b0;
         le_ff      <= 1'b0;
         tag_ff.hit <= 1'b0;
      end else begin
         lt_ff      <= lt_in;
         le_ff      <= le_in;
         tag_ff.hit <= tag_in.hit;
      end
      tag_ff.data <= tag_in.data;
   end

   assign view.lt    = lt_ff;
   assign view.le    = le_ff;
   assign view.value = value_ff;
   assign tag        = tag_ff;

endmodule

// ----- rtl/omre_fold.sv -----
module omre_fold (
   input  logic               clock,
   input  logic               reset,
   input  omre_pkg::tag_type  tags [omre_pkg::FOLD_N],
   output omre_pkg::tag_type  sum
);

   omre_pkg::tag_type sum_ff;
   omre_pkg::tag_type sum_in;

   // at most one input hits, so an or merges them
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < omre_pkg::FOLD_N; i++) begin
         sum_in.hit  = sum_in.hit | tags[i].hit;
         sum_in.data = sum_in.data | (tags[i].hit ? tags[i].data : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff.hit <= 1'b0;
      end else begin
         sum_ff.hit <= sum_in.hit;
      end
      sum_ff.data <= sum_in.data;
   end

   assign sum = sum_ff;

endmodule

// ----- rtl/ordered_multiset_rank_engine.sv -----
// channel  direction  tvalid/tready  tdata                        tuser
// req      in         handshake      [31:0] operand               [2:0] func
// rsp      out        handshake      [31:0] answer, [33:32] status none
//
// the accept edge loads the operand broadcast; the result then passes, in order,
// cell compare, cell candidate, two registered fold levels of 32, then result and
// chain shift. an item is accepted in the cycle after the previous one commits its
// shift, so a new item is not taken while the previous one is still in flight.
// reset clears the fill count, leaving the chain empty; no clearing pass.
// a result waits in the rsp register; the next item may be accepted meanwhile,
// and it holds in its last step only while that earlier result is still untaken.
module ordered_multiset_rank_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [omre_pkg::DATA_W-1:0]   req_tdata,   // [31:0] operand
   input  logic [omre_pkg::FUNC_W-1:0]   req_tuser,   // [2:0] func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [omre_pkg::RSP_W-1:0]    rsp_tdata    // [31:0] answer, [33:32] status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_TAG,
      S_FOLD1,
      S_FOLD2,
      S_RESP
   } state_type;

   localparam omre_pkg::view_type LEFT_EDGE  = '{lt: 1'b1, le: 1'b1, value: '0};
   localparam omre_pkg::view_type RIGHT_EDGE = '{lt: 1'b0, le: 1'b0, value: '0};

   state_type                        state_ff;
   omre_pkg::op_type                 op_ff;
   logic [omre_pkg::CNT_W-1:0]       live_ff;
   logic                             rsp_tvalid_ff;
   logic [omre_pkg::RSP_W-1:0]       rsp_tdata_ff;
   logic [omre_pkg::RSP_W-1:0]       rsp_tdata_in;

   omre_pkg::view_type   views    [omre_pkg::CAPACITY];
   omre_pkg::view_type   lnb      [omre_pkg::CAPACITY];
   omre_pkg::view_type   rnb      [omre_pkg::CAPACITY];
   omre_pkg::tag_type    cell_tags[omre_pkg::GROUPS * omre_pkg::FOLD_N];
   omre_pkg::tag_type    l1_tags  [omre_pkg::L2_GROUPS * omre_pkg::FOLD_N];
   omre_pkg::tag_type    l2_tags  [omre_pkg::L2_GROUPS];
   logic [omre_pkg::CAPACITY-1:0] hit_vec;

   omre_pkg::commit_type             commit;
   omre_pkg::tag_type                fin;
   logic                             slot_free;
   logic                             full;
   logic [omre_pkg::DATA_W-1:0]      answer;
   logic [omre_pkg::STATUS_W-1:0]    status;

   // chain of cells
   for (genvar i = 0; i < omre_pkg::CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign lnb[i] = LEFT_EDGE;
      end else begin : g_mid_l
         assign lnb[i] = views[i-1];
      end
      if (i == omre_pkg::CAPACITY - 1) begin : g_last
         assign rnb[i] = RIGHT_EDGE;
      end else begin : g_mid_r
         assign rnb[i] = views[i+1];
      end

      omre_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (omre_pkg::IDX_W'(i)),
         .live       (live_ff),
         .op         (op_ff),
         .commit     (commit),
         .left       (lnb[i]),
         .right      (rnb[i]),
         .view       (views[i]),
         .tag        (cell_tags[i])
      );

      assign hit_vec[i] = cell_tags[i].hit;
   end

   // pad the tree inputs past the last cell
   for (genvar i = omre_pkg::CAPACITY; i < omre_pkg::GROUPS * omre_pkg::FOLD_N;
        i++) begin : g_pad1
      assign cell_tags[i] = '0;
   end
   for (genvar i = omre_pkg::GROUPS; i < omre_pkg::L2_GROUPS * omre_pkg::FOLD_N;
        i++) begin : g_pad2
      assign l1_tags[i] = '0;
   end

   // first fold level
   for (genvar g = 0; g < omre_pkg::GROUPS; g++) begin : g_fold1
      omre_fold u_fold (
         .clock (clock),
         .reset (reset),
         .tags  (cell_tags[g*omre_pkg::FOLD_N +: omre_pkg::FOLD_N]),
         .sum   (l1_tags[g])
      );
   end

   // second fold level
   for (genvar g = 0; g < omre_pkg::L2_GROUPS; g++) begin : g_fold2
      omre_fold u_fold (
         .clock (clock),
         .reset (reset),
         .tags  (l1_tags[g*omre_pkg::FOLD_N +: omre_pkg::FOLD_N]),
         .sum   (l2_tags[g])
      );
   end

   // last merge of the few second level folds
   always_comb begin
      fin = '0;
      for (int g = 0; g < omre_pkg::L2_GROUPS; g++) begin
         fin.hit  = fin.hit | l2_tags[g].hit;
         fin.data = fin.data | (l2_tags[g].hit ? l2_tags[g].data : '0);
      end
   end

   assign slot_free = !rsp_tvalid_ff || rsp_tready;
   assign full      = live_ff == omre_pkg::CNT_W'(omre_pkg::CAPACITY);

   // result of the current item
   always_comb begin
      answer = '0;
      status = omre_pkg::ST_OK;
      unique case (op_ff.func)
         omre_pkg::FN_INSERT: begin
            status = full ? omre_pkg::ST_FULL : omre_pkg::ST_OK;
         end
         omre_pkg::FN_DELETE: begin
            status = fin.hit ? omre_pkg::ST_OK : omre_pkg::ST_MISSING;
         end
         omre_pkg::FN_RANK: begin
            answer = fin.hit ? fin.data + omre_pkg::DATA_W'(1) : omre_pkg::DATA_W'(1);
         end
         omre_pkg::FN_KTH, omre_pkg::FN_PRED, omre_pkg::FN_SUCC: begin
            answer = fin.hit ? fin.data : '0;
            status = fin.hit ? omre_pkg::ST_OK : omre_pkg::ST_MISSING;
         end
         default: begin
            status = omre_pkg::ST_MISSING;
         end
      endcase
      rsp_tdata_in = {{(omre_pkg::RSP_W - omre_pkg::DATA_W - omre_pkg::STATUS_W){1'b0}},
                      status, answer};
   end

   // shift the chain when the result leaves
   assign commit.ins = (state_ff == S_RESP) && slot_free &&
                       (op_ff.func == omre_pkg::FN_INSERT) && !full;
   assign commit.del = (state_ff == S_RESP) && slot_free &&
                       (op_ff.func == omre_pkg::FN_DELETE) && fin.hit;

   // sequencer, fill count and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         live_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_RESP)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff.func    <= omre_pkg::func_type'(req_tuser);
                  op_ff.operand <= req_tdata;
                  state_ff      <= S_CMP;
               end
            end
            S_CMP:   state_ff <= S_TAG;
            S_TAG:   state_ff <= S_FOLD1;
            S_FOLD1: state_ff <= S_FOLD2;
            S_FOLD2: state_ff <= S_RESP;
            S_RESP: begin
               if (slot_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= rsp_tdata_in;
                  state_ff      <= S_IDLE;
                  if (commit.ins) begin
                     live_ff <= live_ff + omre_pkg::CNT_W'(1);
                  end else if (commit.del) begin
                     live_ff <= live_ff - omre_pkg::CNT_W'(1);
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef ASSERT_OFF
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= omre_pkg::CNT_W'(omre_pkg::CAPACITY))
      else $error("fill count above capacity");

   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FOLD1 |-> $onehot0(hit_vec))
      else $error("more than one cell claims the answer");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      commit.ins |=> live_ff == $past(live_ff) + omre_pkg::CNT_W'(1))
      else $error("insert did not grow the fill count");

   a_del_count: assert property (@(posedge clock) disable iff (reset)
      commit.del |=> live_ff == $past(live_ff) - omre_pkg::CNT_W'(1))
      else $error("delete did not shrink the fill count");
`endif

endmodule
